FILE: rtl/dced_pkg.sv
package dced_pkg;

  // field widths
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned ALPHA_W  = 16;
  localparam int unsigned MINCNT_W = 16;
  localparam int unsigned RATIO_W  = 24;
  localparam int unsigned AVG_W    = 32;
  localparam int unsigned CNT_W    = 32;
  localparam int unsigned CFG_W    = 24;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned UPC_W    = 4;

  localparam logic [RATIO_W-1:0] RATIO_MAX = '1;
  localparam logic [CNT_W-1:0]   CNT_MAX   = '1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FAST_ALPHA   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLOW_ALPHA   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SAMPLES  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RATIO_THRESH = 2'd3;

  localparam logic [ALPHA_W-1:0]  FAST_ALPHA_RST   = 16'd6554;
  localparam logic [ALPHA_W-1:0]  SLOW_ALPHA_RST   = 16'd655;
  localparam logic [MINCNT_W-1:0] MIN_SAMPLES_RST  = 16'd0;
  localparam logic [RATIO_W-1:0]  RATIO_THRESH_RST = 24'd3277;

  // command codes
  localparam logic CMD_RECORD = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  typedef struct packed {
    logic                       command;
    logic signed [SAMPLE_W-1:0] sample;
  } dced_in_t;

  typedef struct packed {
    logic [RATIO_W-1:0]      ratio;
    logic                    fatigued;
    logic                    entry_pulse;
    logic                    exit_pulse;
    logic [CNT_W-1:0]        fatigue_total;
    logic [CNT_W-1:0]        recovery_total;
    logic [CNT_W-1:0]        samples_seen;
    logic signed [AVG_W-1:0] fast_average;
    logic signed [AVG_W-1:0] slow_average;
  } dced_out_t;

  // datapath operations of one microcode step
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_MUL_FAST,
    OP_ADD_FAST,
    OP_MUL_SLOW,
    OP_ADD_SLOW,
    OP_MAG,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_DECIDE,
    OP_CLEAR
  } op_t;

  // jump conditions
  typedef enum logic [2:0] {
    COND_NEXT,
    COND_ALWAYS,
    COND_NO_ITEM,
    COND_CLEAR_CMD,
    COND_SAT,
    COND_DIV_MORE,
    COND_OUT_BUSY
  } cond_t;

  typedef struct packed {
    op_t              op;
    cond_t            cond;
    logic [UPC_W-1:0] target;
  } uword_t;

  // program addresses
  localparam logic [UPC_W-1:0] UA_WAIT      = 4'd0;
  localparam logic [UPC_W-1:0] UA_MUL_FAST  = 4'd1;
  localparam logic [UPC_W-1:0] UA_ADD_FAST  = 4'd2;
  localparam logic [UPC_W-1:0] UA_MUL_SLOW  = 4'd3;
  localparam logic [UPC_W-1:0] UA_ADD_SLOW  = 4'd4;
  localparam logic [UPC_W-1:0] UA_MAG       = 4'd5;
  localparam logic [UPC_W-1:0] UA_DIV_INIT  = 4'd6;
  localparam logic [UPC_W-1:0] UA_DIV_STEP  = 4'd7;
  localparam logic [UPC_W-1:0] UA_OUT_WAIT  = 4'd8;
  localparam logic [UPC_W-1:0] UA_DECIDE    = 4'd9;
  localparam logic [UPC_W-1:0] UA_CLR_WAIT  = 4'd10;
  localparam logic [UPC_W-1:0] UA_CLEAR     = 4'd11;

  function automatic uword_t dced_ucode(input logic [UPC_W-1:0] upc);
    uword_t w;
    w = '{op: OP_NONE, cond: COND_ALWAYS, target: UA_WAIT};
    case (upc)
      UA_WAIT:     w = '{op: OP_LATCH,    cond: COND_NO_ITEM,   target: UA_WAIT};
      UA_MUL_FAST: w = '{op: OP_MUL_FAST, cond: COND_CLEAR_CMD, target: UA_CLR_WAIT};
      UA_ADD_FAST: w = '{op: OP_ADD_FAST, cond: COND_NEXT,      target: UA_WAIT};
      UA_MUL_SLOW: w = '{op: OP_MUL_SLOW, cond: COND_NEXT,      target: UA_WAIT};
      UA_ADD_SLOW: w = '{op: OP_ADD_SLOW, cond: COND_NEXT,      target: UA_WAIT};
      UA_MAG:      w = '{op: OP_MAG,      cond: COND_NEXT,      target: UA_WAIT};
      UA_DIV_INIT: w = '{op: OP_DIV_INIT, cond: COND_SAT,       target: UA_OUT_WAIT};
      UA_DIV_STEP: w = '{op: OP_DIV_STEP, cond: COND_DIV_MORE,  target: UA_DIV_STEP};
      UA_OUT_WAIT: w = '{op: OP_NONE,     cond: COND_OUT_BUSY,  target: UA_OUT_WAIT};
      UA_DECIDE:   w = '{op: OP_DECIDE,   cond: COND_ALWAYS,    target: UA_WAIT};
      UA_CLR_WAIT: w = '{op: OP_NONE,     cond: COND_OUT_BUSY,  target: UA_CLR_WAIT};
      UA_CLEAR:    w = '{op: OP_CLEAR,    cond: COND_ALWAYS,    target: UA_WAIT};
      default:     w = '{op: OP_NONE,     cond: COND_ALWAYS,    target: UA_WAIT};
    endcase
    return w;
  endfunction

endpackage

FILE: rtl/dual_ema_convergence_detector.sv
// dual ema convergence detector
// input channel in_valid / in_stall / in_data carries one item: a command bit
// (record sample or clear all state) and a signed q4.12 sample. every item
// gives exactly one result item on out_valid / out_stall / out_data: ratio,
// fatigue flag, event pulses, saturating totals and both averages.
// a record item runs the multiply and add steps of both averages, the
// magnitude step and, unless the ratio saturates, the divider steps; a clear
// item runs the clear step. the result is loaded as the sequencer returns to
// its first step. the program uses a shared 17x33 multiplier once per average,
// then a radix-2 divider making one quotient bit a cycle for the 24-bit ratio.
// one item is worked at a time; in_stall is low only while the sequencer waits
// at its first step. results land in an output register, so the next item is
// taken while a result still waits; if out_stall holds the register, the
// sequencer waits before its final step until the register frees.
// configuration is a plain write port (cfg_we, cfg_index, cfg_data); the user
// must write it only while the block is idle, which the block does not enforce.
// synchronous active-low reset clears averages, counters and flags, loads the
// register defaults, and leaves the output channel empty.
module dual_ema_convergence_detector (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  dced_pkg::dced_in_t                    in_data,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output dced_pkg::dced_out_t                   out_data,
  input  logic                                  cfg_we,
  input  logic [dced_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [dced_pkg::CFG_W-1:0]            cfg_data
);
  import dced_pkg::*;

  localparam int unsigned DIFF_W = AVG_W + 1;
  localparam int unsigned PROD_W = ALPHA_W + 1 + DIFF_W;
  localparam int unsigned STEP_W = PROD_W - ALPHA_W;
  localparam int unsigned SUM_W  = STEP_W + 1;
  localparam int unsigned QCNT_W = $clog2(RATIO_W);
  localparam logic [QCNT_W-1:0] QCNT_LAST = QCNT_W'(RATIO_W - 1);

  // config registers
  logic [ALPHA_W-1:0]  fast_alpha_r, fast_alpha_nxt;
  logic [ALPHA_W-1:0]  slow_alpha_r, slow_alpha_nxt;
  logic [MINCNT_W-1:0] min_cnt_r, min_cnt_nxt;
  logic [RATIO_W-1:0]  thresh_r, thresh_nxt;

  // sequencer
  logic [UPC_W-1:0] upc_r, upc_nxt;
  uword_t           uw;
  logic             cond_hit;

  // state
  logic signed [AVG_W-1:0] fast_r, fast_nxt;
  logic signed [AVG_W-1:0] slow_r, slow_nxt;
  logic                    prev_r, prev_nxt;
  logic [CNT_W-1:0]        smp_cnt_r, smp_cnt_nxt;
  logic [CNT_W-1:0]        fat_cnt_r, fat_cnt_nxt;
  logic [CNT_W-1:0]        rec_cnt_r, rec_cnt_nxt;

  // datapath
  dced_in_t                 item_r, item_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic [DIFF_W-1:0]        mag_r, mag_nxt;
  logic [AVG_W-1:0]         den_r, den_nxt;
  logic [AVG_W-1:0]         rem_r, rem_nxt;
  logic [RATIO_W-1:0]       low_r, low_nxt;
  logic [RATIO_W-1:0]       quo_r, quo_nxt;
  logic                     sat_r, sat_nxt;
  logic [QCNT_W-1:0]        qcnt_r, qcnt_nxt;

  logic      out_valid_r, out_valid_nxt;
  dced_out_t out_r, out_nxt;

  // combinational helpers
  logic [ALPHA_W-1:0]       mul_alpha;
  logic signed [AVG_W-1:0]  mul_avg;
  logic signed [DIFF_W-1:0] mul_diff;
  logic signed [PROD_W-1:0] mul_p;
  logic signed [AVG_W-1:0]  add_avg;
  logic signed [SUM_W-1:0]  add_sum;
  logic signed [AVG_W-1:0]  add_res;
  logic signed [DIFF_W-1:0] fs_diff;
  logic signed [DIFF_W-1:0] slow_ext;
  logic [DIFF_W-1:0]        slow_mag;
  logic                     sat_w;
  logic [AVG_W:0]           rem_sh;
  logic [AVG_W:0]           rem_sub;
  logic [RATIO_W-1:0]       ratio_w;
  logic                     active_w;
  logic                     fat_w;
  logic                     fev_w;
  logic                     rev_w;
  logic                     out_busy;

  assign uw       = dced_ucode(upc_r);
  assign in_stall = (upc_r != UA_WAIT);
  assign out_busy = out_valid_r && out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // shared multiplier and accumulator
  always_comb begin
    if (uw.op == OP_MUL_SLOW) begin
      mul_alpha = slow_alpha_r;
      mul_avg   = slow_r;
    end else begin
      mul_alpha = fast_alpha_r;
      mul_avg   = fast_r;
    end
    mul_diff = $signed({item_r.sample[SAMPLE_W-1], item_r.sample, {(AVG_W-SAMPLE_W){1'b0}}})
             - $signed({mul_avg[AVG_W-1], mul_avg});
    mul_p    = $signed({1'b0, mul_alpha}) * mul_diff;

    add_avg = (uw.op == OP_ADD_SLOW) ? slow_r : fast_r;
    // floor of alpha*diff / 2^16 is the arithmetic shift of the product
    add_sum = $signed({{(SUM_W-AVG_W){add_avg[AVG_W-1]}}, add_avg})
            + $signed({prod_r[PROD_W-1], prod_r[PROD_W-1:ALPHA_W]});
    if (add_sum[SUM_W-1:AVG_W-1] == '0 || add_sum[SUM_W-1:AVG_W-1] == '1) begin
      add_res = add_sum[AVG_W-1:0];
    end else if (add_sum[SUM_W-1]) begin
      add_res = {1'b1, {(AVG_W-1){1'b0}}};
    end else begin
      add_res = {1'b0, {(AVG_W-1){1'b1}}};
    end
  end

  // magnitudes, divider step and decision
  always_comb begin
    fs_diff  = $signed({fast_r[AVG_W-1], fast_r}) - $signed({slow_r[AVG_W-1], slow_r});
    slow_ext = $signed({slow_r[AVG_W-1], slow_r});
    slow_mag = slow_ext[DIFF_W-1] ? DIFF_W'(-slow_ext) : DIFF_W'(slow_ext);

    // quotient would need more than 24 bits
    sat_w = {{(RATIO_W-8-1){1'b0}}, mag_r} >= {den_r, 8'd0};

    rem_sh  = {rem_r, low_r[RATIO_W-1]};
    rem_sub = rem_sh - {1'b0, den_r};

    ratio_w  = sat_r ? RATIO_MAX : quo_r;
    active_w = smp_cnt_r >= {{(CNT_W-MINCNT_W){1'b0}}, min_cnt_r};
    fat_w    = active_w && (ratio_w < thresh_r);
    fev_w    = fat_w && !prev_r;
    rev_w    = active_w && !fat_w && prev_r;
  end

  // sequencer next step
  always_comb begin
    case (uw.cond)
      COND_NEXT:      cond_hit = 1'b0;
      COND_ALWAYS:    cond_hit = 1'b1;
      COND_NO_ITEM:   cond_hit = !in_valid;
      COND_CLEAR_CMD: cond_hit = (item_r.command == CMD_CLEAR);
      COND_SAT:       cond_hit = sat_w;
      COND_DIV_MORE:  cond_hit = (qcnt_r != '0);
      COND_OUT_BUSY:  cond_hit = out_busy;
      default:        cond_hit = 1'b0;
    endcase
    upc_nxt = cond_hit ? uw.target : upc_r + 1'b1;
  end

  // register next values
  always_comb begin
    fast_alpha_nxt = fast_alpha_r;
    slow_alpha_nxt = slow_alpha_r;
    min_cnt_nxt    = min_cnt_r;
    thresh_nxt     = thresh_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_FAST_ALPHA:   fast_alpha_nxt = cfg_data[ALPHA_W-1:0];
        REG_SLOW_ALPHA:   slow_alpha_nxt = cfg_data[ALPHA_W-1:0];
        REG_MIN_SAMPLES:  min_cnt_nxt    = cfg_data[MINCNT_W-1:0];
        REG_RATIO_THRESH: thresh_nxt     = cfg_data[RATIO_W-1:0];
        default: ;
      endcase
    end

    fast_nxt    = fast_r;
    slow_nxt    = slow_r;
    prev_nxt    = prev_r;
    smp_cnt_nxt = smp_cnt_r;
    fat_cnt_nxt = fat_cnt_r;
    rec_cnt_nxt = rec_cnt_r;
    item_nxt    = item_r;
    prod_nxt    = prod_r;
    mag_nxt     = mag_r;
    den_nxt     = den_r;
    rem_nxt     = rem_r;
    low_nxt     = low_r;
    quo_nxt     = quo_r;
    sat_nxt     = sat_r;
    qcnt_nxt    = qcnt_r;
    out_nxt     = out_r;
    out_valid_nxt = out_busy;

    case (uw.op)
      OP_LATCH: begin
        if (in_valid) begin
          item_nxt = in_data;
        end
      end
      OP_MUL_FAST, OP_MUL_SLOW: prod_nxt = mul_p;
      OP_ADD_FAST: fast_nxt = add_res;
      OP_ADD_SLOW: slow_nxt = add_res;
      OP_MAG: begin
        mag_nxt = fs_diff[DIFF_W-1] ? DIFF_W'(-fs_diff) : DIFF_W'(fs_diff);
        den_nxt = AVG_W'(slow_mag + 1'b1);
      end
      OP_DIV_INIT: begin
        sat_nxt  = sat_w;
        rem_nxt  = {{(AVG_W-(DIFF_W-8)){1'b0}}, mag_r[DIFF_W-1:8]};
        low_nxt  = {mag_r[7:0], {(RATIO_W-8){1'b0}}};
        quo_nxt  = '0;
        qcnt_nxt = QCNT_LAST;
      end
      OP_DIV_STEP: begin
        // restoring step: one quotient bit a cycle
        if (!rem_sub[AVG_W]) begin
          rem_nxt = rem_sub[AVG_W-1:0];
          quo_nxt = {quo_r[RATIO_W-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh[AVG_W-1:0];
          quo_nxt = {quo_r[RATIO_W-2:0], 1'b0};
        end
        low_nxt  = {low_r[RATIO_W-2:0], 1'b0};
        qcnt_nxt = qcnt_r - 1'b1;
      end
      OP_DECIDE: begin
        if (active_w) begin
          prev_nxt = fat_w;
        end
        if (fev_w && fat_cnt_r != CNT_MAX) begin
          fat_cnt_nxt = fat_cnt_r + 1'b1;
        end
        if (rev_w && rec_cnt_r != CNT_MAX) begin
          rec_cnt_nxt = rec_cnt_r + 1'b1;
        end
        if (smp_cnt_r != CNT_MAX) begin
          smp_cnt_nxt = smp_cnt_r + 1'b1;
        end
        out_nxt.ratio          = ratio_w;
        out_nxt.fatigued       = fat_w;
        out_nxt.entry_pulse    = fev_w;
        out_nxt.exit_pulse     = rev_w;
        out_nxt.fatigue_total  = fat_cnt_nxt;
        out_nxt.recovery_total = rec_cnt_nxt;
        out_nxt.samples_seen   = smp_cnt_nxt;
        out_nxt.fast_average   = fast_r;
        out_nxt.slow_average   = slow_r;
        out_valid_nxt = 1'b1;
      end
      OP_CLEAR: begin
        fast_nxt    = '0;
        slow_nxt    = '0;
        prev_nxt    = 1'b0;
        smp_cnt_nxt = '0;
        fat_cnt_nxt = '0;
        rec_cnt_nxt = '0;
        out_nxt     = '0;
        out_valid_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fast_alpha_r <= FAST_ALPHA_RST;
      slow_alpha_r <= SLOW_ALPHA_RST;
      min_cnt_r    <= MIN_SAMPLES_RST;
      thresh_r     <= RATIO_THRESH_RST;
      upc_r        <= UA_WAIT;
      fast_r       <= '0;
      slow_r       <= '0;
      prev_r       <= 1'b0;
      smp_cnt_r    <= '0;
      fat_cnt_r    <= '0;
      rec_cnt_r    <= '0;
      out_valid_r  <= 1'b0;
      qcnt_r       <= '0;
    end else begin
      fast_alpha_r <= fast_alpha_nxt;
      slow_alpha_r <= slow_alpha_nxt;
      min_cnt_r    <= min_cnt_nxt;
      thresh_r     <= thresh_nxt;
      upc_r        <= upc_nxt;
      fast_r       <= fast_nxt;
      slow_r       <= slow_nxt;
      prev_r       <= prev_nxt;
      smp_cnt_r    <= smp_cnt_nxt;
      fat_cnt_r    <= fat_cnt_nxt;
      rec_cnt_r    <= rec_cnt_nxt;
      out_valid_r  <= out_valid_nxt;
      qcnt_r       <= qcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    prod_r <= prod_nxt;
    mag_r  <= mag_nxt;
    den_r  <= den_nxt;
    rem_r  <= rem_nxt;
    low_r  <= low_nxt;
    quo_r  <= quo_nxt;
    sat_r  <= sat_nxt;
    out_r  <= out_nxt;
  end

  // a new result only comes out of the two final steps
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $rose(out_valid_r) |->
      ($past(upc_r) == UA_DECIDE || $past(upc_r) == UA_CLEAR))
    else $error("result register loaded outside a final step");

  // the final steps are only reached with the output register free
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (upc_r == UA_DECIDE || upc_r == UA_CLEAR) |-> !out_valid_r)
    else $error("pending result would be overwritten");

  // divider remainder stays below the divisor
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && upc_r == UA_DIV_STEP |-> rem_r < den_r)
    else $error("divider remainder out of range");

  // event totals only move in a final step
  a_cnt_move: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && (fat_cnt_r != $past(fat_cnt_r) || rec_cnt_r != $past(rec_cnt_r)) |->
      ($past(upc_r) == UA_DECIDE || $past(upc_r) == UA_CLEAR))
    else $error("event total changed outside a final step");

  // entering and leaving fatigue never pulse together
  a_events: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_r.entry_pulse && out_r.exit_pulse))
    else $error("both event pulses set");

endmodule
